// ===== src/c3g_pkg.sv =====
// c3g_pkg: shared types, constants and register codes of the 3x3 grayscale
// convolution stream block. No dependencies.

package c3g_pkg;

  localparam int unsigned PIX_W       = 8;   // pixel bits
  localparam int unsigned COL_W       = 11;  // frame_width register / column count
  localparam int unsigned ROW_W       = 16;  // frame_height register / row count
  localparam int unsigned COEF_W      = 16;  // one signed Q8.8 coefficient
  localparam int unsigned COEF_ROW_W  = 3 * COEF_W;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = COEF_ROW_W;
  localparam int unsigned KERNEL_TAPS = 9;
  localparam int unsigned KERNEL_DIM  = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MAX_WIDTH_DEF = 1024;

  // geometry limits
  localparam int unsigned MIN_DIM   = 3;
  localparam int unsigned WIN_REACH = 2;  // first column / row position with a full window

  // products and sums
  localparam int unsigned PROD_W = PIX_W + 1 + COEF_W;  // 25
  localparam int unsigned ROWS_W = PROD_W + 2;          // sum of three
  localparam int unsigned SUM_W  = PROD_W + 4;          // sum of nine
  localparam int unsigned FRAC_W = 8;                   // Q8.8 fraction bits

  // reset values
  localparam logic [COL_W-1:0]      WIDTH_RST  = COL_W'(640);
  localparam logic [ROW_W-1:0]      HEIGHT_RST = ROW_W'(480);
  localparam logic [COEF_ROW_W-1:0] COEF_OUTER_RST = 48'hFF00_FF00_FF00;
  localparam logic [COEF_ROW_W-1:0] COEF_MID_RST   = 48'hFF00_0800_FF00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MIDDLE  = 3'd3,
    REG_COEF_BOTTOM  = 3'd4
  } cfg_reg_e;

  // one 3x3 neighborhood handed from front to back; index row*3 + column,
  // row 0 = top, column 0 = left
  typedef struct packed {
    logic [KERNEL_TAPS-1:0][PIX_W-1:0] win;
    logic                              last;
  } item_t;

  typedef struct packed {
    logic [COEF_ROW_W-1:0] top;
    logic [COEF_ROW_W-1:0] middle;
    logic [COEF_ROW_W-1:0] bottom;
  } kernel_t;

endpackage

// ===== src/c3g_front.sv =====
// c3g_front: raster position tracking, two line stores (one 16-bit RAM) and
// the 3x3 window. Pushes interior neighborhoods into the queue. Uses c3g_pkg.

module c3g_front #(
  parameter int unsigned MAX_WIDTH = c3g_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [c3g_pkg::PIX_W-1:0]     pixel_i,
  input  logic                          frame_start_i,
  input  logic [c3g_pkg::COL_W-1:0]     frame_width_i,
  input  logic [c3g_pkg::ROW_W-1:0]     frame_height_i,
  output logic                          push_o,
  output c3g_pkg::item_t                push_item_o,
  input  logic                          queue_full_i
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned PW = c3g_pkg::PIX_W;

  // line store entry: older row in upper byte, newer row in lower byte
  logic [2*PW-1:0] mem [MAX_WIDTH];

  logic [c3g_pkg::COL_W-1:0] col_q, col_d;
  logic [c3g_pkg::ROW_W-1:0] row_q, row_d;
  logic [c3g_pkg::COL_W-1:0] w_use;
  logic [c3g_pkg::ROW_W-1:0] h_use;
  logic [c3g_pkg::COL_W-1:0] cur_c;
  logic [c3g_pkg::ROW_W:0]   cur_r;
  logic [c3g_pkg::COL_W:0]   nxt_c;
  logic [c3g_pkg::ROW_W:0]   nxt_r;
  logic                      cur_emit, cur_last;

  logic          accept, adv;
  logic          v1_q, emit1_q, last1_q;
  logic [PW-1:0] px1_q;
  logic [AW-1:0] addr1_q, rd_addr;
  logic [2*PW-1:0] rd_q, byp_data_q, rd_eff, wr_data;
  logic            byp_q;

  logic [c3g_pkg::KERNEL_TAPS-1:0][PW-1:0] win_q, win_d;

  // geometry in use
  always_comb begin
    w_use = frame_width_i;
    if (32'(frame_width_i) > MAX_WIDTH) w_use = c3g_pkg::COL_W'(MAX_WIDTH);
    if (w_use < c3g_pkg::COL_W'(c3g_pkg::MIN_DIM)) w_use = c3g_pkg::COL_W'(c3g_pkg::MIN_DIM);
    h_use = frame_height_i;
    if (h_use < c3g_pkg::ROW_W'(c3g_pkg::MIN_DIM)) h_use = c3g_pkg::ROW_W'(c3g_pkg::MIN_DIM);
  end

  // position of the incoming word and position after it
  always_comb begin
    cur_c = col_q;
    cur_r = {1'b0, row_q};
    if (frame_start_i) begin
      cur_c = '0;
      cur_r = '0;
    end
    if (cur_c >= w_use) begin
      cur_c = '0;
      cur_r = cur_r + 1'b1;
    end
    if (cur_r >= {1'b0, h_use}) cur_r = '0;

    nxt_c = {1'b0, cur_c} + 1'b1;
    nxt_r = cur_r;
    if (nxt_c >= {1'b0, w_use}) begin
      nxt_c = '0;
      nxt_r = cur_r + 1'b1;
      if (nxt_r >= {1'b0, h_use}) nxt_r = '0;
    end
    col_d = nxt_c[c3g_pkg::COL_W-1:0];
    row_d = nxt_r[c3g_pkg::ROW_W-1:0];

    cur_emit = (cur_r >= (c3g_pkg::ROW_W+1)'(c3g_pkg::WIN_REACH)) &&
               (cur_c >= c3g_pkg::COL_W'(c3g_pkg::WIN_REACH));
    cur_last = (cur_r[c3g_pkg::ROW_W-1:0] == h_use - 1'b1) && (cur_c == w_use - 1'b1);
  end

  assign rd_addr    = AW'(cur_c);
  assign adv        = v1_q && (!emit1_q || !queue_full_i);
  assign in_ready_o = !v1_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  // same-address read right after a write (repeated frame start) takes the bypass
  assign rd_eff  = byp_q ? byp_data_q : rd_q;
  assign wr_data = {rd_eff[PW-1:0], px1_q};

  always_ff @(posedge clk_i) begin
    if (adv) mem[addr1_q] <= wr_data;
    if (accept) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_ready_o) v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q      <= pixel_i;
      emit1_q    <= cur_emit;
      last1_q    <= cur_last;
      addr1_q    <= rd_addr;
      byp_q      <= adv && (addr1_q == rd_addr);
      byp_data_q <= wr_data;
    end
    if (adv) win_q <= win_d;
  end

  // window shift: new column on the right
  always_comb begin
    win_d = win_q;
    for (int k = 0; k < c3g_pkg::KERNEL_DIM; k++) begin
      win_d[k*3]     = win_q[k*3 + 1];
      win_d[k*3 + 1] = win_q[k*3 + 2];
    end
    win_d[2] = rd_eff[2*PW-1:PW];
    win_d[5] = rd_eff[PW-1:0];
    win_d[8] = px1_q;
  end

  assign push_o           = adv && emit1_q;
  assign push_item_o.win  = win_d;
  assign push_item_o.last = last1_q;

endmodule

// ===== src/c3g_queue.sv =====
// c3g_queue: short FIFO of neighborhoods between front and back.
// Uses c3g_pkg for the item type and depth.

module c3g_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  c3g_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output c3g_pkg::item_t pop_item_o
);

  localparam int unsigned PTR_W = $clog2(c3g_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(c3g_pkg::QUEUE_DEPTH + 1);

  c3g_pkg::item_t slots_q [c3g_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(c3g_pkg::QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_item_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// ===== src/c3g_back.sv =====
// c3g_back: three-stage multiply / add / floor-and-saturate pipeline whose last
// stage is the output register. Uses c3g_pkg.

module c3g_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  c3g_pkg::item_t            q_item_i,
  output logic                      q_pop_o,
  input  c3g_pkg::kernel_t          kernel_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [c3g_pkg::PIX_W-1:0] out_data_o,
  output logic                      out_last_o
);

  localparam int unsigned TAPS = c3g_pkg::KERNEL_TAPS;
  localparam int unsigned DIM  = c3g_pkg::KERNEL_DIM;
  localparam int unsigned CW   = c3g_pkg::COEF_W;

  logic en;
  logic p_v_q, s_v_q, o_v_q;
  logic p_last_q, s_last_q, o_last_q;
  logic signed [c3g_pkg::PROD_W-1:0] prod_q [TAPS];
  logic signed [c3g_pkg::ROWS_W-1:0] rsum_q [DIM];
  logic [DIM-1:0][c3g_pkg::COEF_ROW_W-1:0] krow;
  logic signed [c3g_pkg::SUM_W-1:0] total;
  logic signed [c3g_pkg::SUM_W-c3g_pkg::FRAC_W-1:0] shifted;
  logic [c3g_pkg::PIX_W-1:0] sat, o_data_q;

  assign en      = !o_v_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;
  assign krow    = {kernel_i.bottom, kernel_i.middle, kernel_i.top};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      s_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= q_valid_i;
      s_v_q <= p_v_q;
      o_v_q <= s_v_q;
    end
  end

  // nine pixel x coefficient products, one lane each
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < TAPS; i++) begin
        prod_q[i] <= $signed({1'b0, q_item_i.win[i]}) *
                     $signed(krow[i / DIM][(i % DIM)*CW +: CW]);
      end
      p_last_q <= q_item_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < DIM; k++) begin
        rsum_q[k] <= c3g_pkg::ROWS_W'(prod_q[k*3]) + c3g_pkg::ROWS_W'(prod_q[k*3 + 1]) +
                     c3g_pkg::ROWS_W'(prod_q[k*3 + 2]);
      end
      s_last_q <= p_last_q;
    end
  end

  // floor by arithmetic shift, then clamp to 0..255
  always_comb begin
    total   = c3g_pkg::SUM_W'(rsum_q[0]) + c3g_pkg::SUM_W'(rsum_q[1]) +
              c3g_pkg::SUM_W'(rsum_q[2]);
    shifted = total[c3g_pkg::SUM_W-1:c3g_pkg::FRAC_W];
    if (shifted < 0)
      sat = '0;
    else if (shifted > $signed((c3g_pkg::SUM_W-c3g_pkg::FRAC_W)'({c3g_pkg::PIX_W{1'b1}})))
      sat = '1;
    else
      sat = shifted[c3g_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_data_q <= sat;
      o_last_q <= s_last_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_data_q;
  assign out_last_o  = o_last_q;

endmodule

// ===== src/conv3x3_gray_stream.sv =====
// conv3x3_gray_stream: top level of the 3x3 grayscale convolution stream.
// Holds the configuration registers; instantiates c3g_front, c3g_queue, c3g_back.
//
//  port group   dir   word content (low bit first)       end of frame
//  s_axis_*     in    tdata: pixel, tuser: frame_start   -
//  m_axis_*     out   tdata: filtered                     tlast: frame_last
//  cfg_*_i      in    index 0..4, data up to 48 bits      -
//
// Throughput: one pixel word per clock until a stalled output fills the queue; the
// line-store RAM is read once and written once per word (one read port, one write
// port). Word path: front register, queue, product, row-sum and output registers.
// Border positions produce no output word; interior results leave in raster order.
// Reset is asynchronous; it clears counters and valid flags and sets the config
// registers to defaults; line stores are not cleared (no clearing pass), so the
// block is ready right after reset. Output stall backs up the 3-stage math pipe,
// then the 4-entry queue, and only then drops s_axis_tready.

module conv3x3_gray_stream #(
  parameter int unsigned MAX_WIDTH = c3g_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input pixel stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]                     s_axis_tuser,   // [0] frame_start
  // filtered stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] filtered
  output logic                           m_axis_tlast,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [c3g_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [c3g_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [c3g_pkg::COL_W-1:0] frame_width_q;
  logic [c3g_pkg::ROW_W-1:0] frame_height_q;
  c3g_pkg::kernel_t          kernel_q;

  logic           push, q_full, q_valid, q_pop;
  c3g_pkg::item_t push_item, pop_item;

  // register file; unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= c3g_pkg::WIDTH_RST;
      frame_height_q  <= c3g_pkg::HEIGHT_RST;
      kernel_q.top    <= c3g_pkg::COEF_OUTER_RST;
      kernel_q.middle <= c3g_pkg::COEF_MID_RST;
      kernel_q.bottom <= c3g_pkg::COEF_OUTER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        c3g_pkg::REG_FRAME_WIDTH:  frame_width_q   <= cfg_data_i[c3g_pkg::COL_W-1:0];
        c3g_pkg::REG_FRAME_HEIGHT: frame_height_q  <= cfg_data_i[c3g_pkg::ROW_W-1:0];
        c3g_pkg::REG_COEF_TOP:     kernel_q.top    <= cfg_data_i;
        c3g_pkg::REG_COEF_MIDDLE:  kernel_q.middle <= cfg_data_i;
        c3g_pkg::REG_COEF_BOTTOM:  kernel_q.bottom <= cfg_data_i;
        default: ;
      endcase
    end
  end

  c3g_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .pixel_i        (s_axis_tdata),
    .frame_start_i  (s_axis_tuser[0]),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .push_o         (push),
    .push_item_o    (push_item),
    .queue_full_i   (q_full)
  );

  c3g_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  c3g_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .kernel_i    (kernel_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
